/* hw/rtl/psi_pkg.sv */
// package: types, constants and command codes of the permutation shortcut inverse unit
package psi_pkg;

  localparam int unsigned MAX_ELEMENTS = 1024;
  localparam int unsigned INDEX_BITS   = 10;
  localparam int unsigned CNT_BITS     = INDEX_BITS + 1;
  localparam int unsigned STEP_BITS    = 8;
  localparam int unsigned CFG_IDX_BITS = 1;

  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_FWD  = 2'd1;
  localparam logic [1:0] REQ_INV  = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_RANGE     = 2'd1;
  localparam logic [1:0] ST_NOT_READY = 2'd2;
  localparam logic [1:0] ST_CORRUPT   = 2'd3;

  localparam logic [CFG_IDX_BITS-1:0] CFG_SAMPLE_STEP = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IDS_AT_ONE  = 1'd1;

  typedef struct packed {
    logic [1:0]            req_type;
    logic [INDEX_BITS-1:0] operand;
    logic                  last;
  } psi_in_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0] result_value;
    logic [1:0]            status;
  } psi_out_t;

  typedef enum logic [4:0] {
    OP_IDLE, OP_ACCEPT, OP_LD_PREP, OP_LD_ELEM, OP_CLR,
    OP_F_RD, OP_F_V, OP_F_CHK, OP_B_RD, OP_B_VIS, OP_B_CHK,
    OP_QSEL, OP_FWD, OP_FINV, OP_Q1, OP_Q2, OP_RESP
  } psi_op_e;

  typedef struct packed {
    logic       last;
    logic [1:0] req;
    logic       clr_end;
    logic       step_full;
    logic       idx_end;
    logic       vis_hit;
    logic       walk_end;
    logic       q_err;
    logic       full;
    logic       q_fin;
    logic       q_jump;
    logic       out_free;
  } psi_sts_t;

endpackage

/* hw/rtl/psi_ctrl.sv */
// controller: sequences loads, table build and queries
module psi_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [1:0]        in_req_i,
  input  psi_pkg::psi_sts_t sts_i,
  output psi_pkg::psi_op_e  op_o,
  output logic              in_stall_o
);
  import psi_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_LD_PREP, S_LD_ELEM, S_CLR, S_F_RD, S_F_V, S_F_CHK,
    S_B_RD, S_B_VIS, S_B_CHK, S_QSEL, S_FWD, S_FINV, S_Q1, S_Q2, S_RESP
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    unique case (state_q)
      S_IDLE:    op_o = in_valid_i ? OP_ACCEPT : OP_IDLE;
      S_LD_PREP: op_o = OP_LD_PREP;
      S_LD_ELEM: op_o = OP_LD_ELEM;
      S_CLR:     op_o = OP_CLR;
      S_F_RD:    op_o = OP_F_RD;
      S_F_V:     op_o = OP_F_V;
      S_F_CHK:   op_o = OP_F_CHK;
      S_B_RD:    op_o = OP_B_RD;
      S_B_VIS:   op_o = OP_B_VIS;
      S_B_CHK:   op_o = OP_B_CHK;
      S_QSEL:    op_o = OP_QSEL;
      S_FWD:     op_o = OP_FWD;
      S_FINV:    op_o = OP_FINV;
      S_Q1:      op_o = OP_Q1;
      S_Q2:      op_o = OP_Q2;
      S_RESP:    op_o = OP_RESP;
      default:   op_o = OP_IDLE;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_req_i == REQ_LOAD) state_d = S_LD_PREP;
          else if (in_req_i == REQ_FWD || in_req_i == REQ_INV) state_d = S_QSEL;
          else state_d = S_RESP;
        end
      end
      S_LD_PREP: state_d = S_LD_ELEM;
      S_LD_ELEM: state_d = sts_i.last ? S_CLR : S_RESP;
      S_CLR: if (sts_i.clr_end) state_d = sts_i.step_full ? S_F_RD : S_B_RD;
      S_F_RD:  state_d = sts_i.idx_end ? S_RESP : S_F_V;
      S_F_V:   state_d = S_F_CHK;
      S_F_CHK: state_d = S_F_RD;
      S_B_RD:  state_d = sts_i.idx_end ? S_RESP : S_B_VIS;
      S_B_VIS: state_d = sts_i.vis_hit ? S_B_RD : S_B_CHK;
      S_B_CHK: if (sts_i.walk_end) state_d = S_B_RD;
      S_QSEL: begin
        if (sts_i.q_err) state_d = S_RESP;
        else if (sts_i.req == REQ_FWD) state_d = S_FWD;
        else if (sts_i.full) state_d = S_FINV;
        else state_d = S_Q1;
      end
      S_FWD:  state_d = S_RESP;
      S_FINV: state_d = S_RESP;
      S_Q1: begin
        if (sts_i.q_fin) state_d = S_RESP;
        else if (sts_i.q_jump) state_d = S_Q2;
      end
      S_Q2: if (sts_i.q_fin) state_d = S_RESP;
      S_RESP: if (sts_i.out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (op_o != OP_ACCEPT)) else $error("accept while busy");
  a_resp_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESP && sts_i.out_free) |=> (state_q == S_IDLE))
    else $error("response did not return to idle");
  a_idle_from_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && in_valid_i) |=> (state_q != S_IDLE))
    else $error("accepted word not processed");

endmodule

/* hw/rtl/psi_dp.sv */
// datapath: permutation, mark, visited and pointer memories with walk registers
module psi_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  psi_pkg::psi_op_e                    op_i,
  input  psi_pkg::psi_in_t                    in_word_i,
  input  logic                                cfg_we_i,
  input  logic [psi_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  logic [psi_pkg::STEP_BITS-1:0]       cfg_data_i,
  input  logic                                out_stall_i,
  output logic                                out_valid_o,
  output psi_pkg::psi_out_t                   out_word_o,
  output psi_pkg::psi_sts_t                   sts_o
);
  import psi_pkg::*;

  logic [INDEX_BITS-1:0] perm_mem [MAX_ELEMENTS];
  logic [INDEX_BITS-1:0] bp_mem   [MAX_ELEMENTS];
  logic                  mark_mem [MAX_ELEMENTS];
  logic                  vis_mem  [MAX_ELEMENTS];

  logic [INDEX_BITS-1:0] perm_rd, bp_rd;
  logic                  mark_rd, vis_rd;
  logic [INDEX_BITS-1:0] rd_addr;

  logic                  perm_we, bp_we, mark_we, vis_we;
  logic [INDEX_BITS-1:0] perm_wa, bp_wa, mark_wa, vis_wa;
  logic [INDEX_BITS-1:0] perm_wd, bp_wd;
  logic                  mark_wd, vis_wd;

  logic [1:0]            req_q;
  logic [INDEX_BITS-1:0] opnd_q;
  logic                  last_q;
  logic [CNT_BITS-1:0]   cnt_q;
  logic                  built_q, full_q, bad_q;
  logic [STEP_BITS-1:0]  step_q;
  logic                  ids_q;
  logic [CNT_BITS-1:0]   i_q, cyc_q, walk_q;
  logic [INDEX_BITS-1:0] j_q, ptr_q, res_q;
  logic [STEP_BITS-1:0]  aux_q;
  logic [1:0]            sts_q;
  logic                  out_valid_q;
  psi_out_t              out_q;

  logic [STEP_BITS-1:0]  step_eff;
  logic [CNT_BITS-1:0]   cnt_eff;
  logic                  pad, room, close, brk, aux_hit, match, bp_bad, out_free;

  assign step_eff = (step_q == '0) ? STEP_BITS'(1) : step_q;
  assign cnt_eff  = built_q ? '0 : cnt_q;
  assign pad      = (cnt_eff == '0) && ids_q;
  assign room     = (cnt_q < CNT_BITS'(MAX_ELEMENTS));
  assign close    = (perm_rd == i_q[INDEX_BITS-1:0]);
  assign brk      = ({1'b0, perm_rd} >= cnt_q) || (walk_q >= cnt_q);
  assign aux_hit  = ({1'b0, aux_q} + (STEP_BITS+1)'(1)) >= {1'b0, step_eff};
  assign match    = (perm_rd == opnd_q);
  assign bp_bad   = ({1'b0, bp_rd} >= cnt_q);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    unique case (op_i)
      OP_F_V, OP_B_CHK, OP_Q2: rd_addr = perm_rd;
      OP_F_RD, OP_B_RD, OP_B_VIS: rd_addr = i_q[INDEX_BITS-1:0];
      OP_QSEL: rd_addr = opnd_q;
      OP_Q1:   rd_addr = mark_rd ? bp_rd : perm_rd;
      default: rd_addr = j_q;
    endcase
  end

  always_comb begin
    perm_we = 1'b0; perm_wa = cnt_q[INDEX_BITS-1:0]; perm_wd = opnd_q;
    bp_we = 1'b0;   bp_wa = i_q[INDEX_BITS-1:0];     bp_wd = ptr_q;
    mark_we = 1'b0; mark_wa = i_q[INDEX_BITS-1:0];   mark_wd = 1'b1;
    vis_we = 1'b0;  vis_wa = i_q[INDEX_BITS-1:0];    vis_wd = 1'b1;
    unique case (op_i)
      OP_LD_PREP: begin
        perm_we = pad; perm_wa = '0; perm_wd = '0;
      end
      OP_LD_ELEM: perm_we = room;
      OP_CLR: begin
        bp_we = 1'b1; bp_wd = '0;
        mark_we = 1'b1; mark_wd = 1'b0;
        vis_we = 1'b1; vis_wd = 1'b0;
      end
      OP_F_CHK: begin
        vis_we = !({1'b0, j_q} >= cnt_q) && !vis_rd; vis_wa = j_q;
        bp_we = vis_we; bp_wa = j_q; bp_wd = i_q[INDEX_BITS-1:0];
      end
      OP_B_VIS: vis_we = !vis_rd;
      OP_B_CHK: begin
        if (close) begin
          mark_we = (cyc_q >= CNT_BITS'(step_eff));
          bp_we = mark_we;
        end else if (!brk) begin
          vis_we = 1'b1; vis_wa = perm_rd;
          mark_we = aux_hit; mark_wa = perm_rd;
          bp_we = aux_hit; bp_wa = perm_rd;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (perm_we) perm_mem[perm_wa] <= perm_wd;
    if (bp_we) bp_mem[bp_wa] <= bp_wd;
    if (mark_we) mark_mem[mark_wa] <= mark_wd;
    if (vis_we) vis_mem[vis_wa] <= vis_wd;
    perm_rd <= perm_mem[rd_addr];
    bp_rd   <= bp_mem[rd_addr];
    mark_rd <= mark_mem[rd_addr];
    vis_rd  <= vis_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      built_q     <= 1'b0;
      full_q      <= 1'b0;
      step_q      <= STEP_BITS'(8);
      ids_q       <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_SAMPLE_STEP) step_q <= cfg_data_i;
        else if (cfg_index_i == CFG_IDS_AT_ONE) ids_q <= cfg_data_i[0];
      end
      unique case (op_i)
        OP_ACCEPT: begin
          req_q  <= in_word_i.req_type;
          opnd_q <= in_word_i.operand;
          last_q <= in_word_i.last;
          res_q  <= '0;
          sts_q  <= ST_OK;
          bad_q  <= 1'b0;
        end
        OP_LD_PREP: begin
          built_q <= 1'b0;
          cnt_q   <= pad ? CNT_BITS'(1) : cnt_eff;
        end
        OP_LD_ELEM: begin
          if (room) cnt_q <= cnt_q + CNT_BITS'(1);
          else sts_q <= ST_NOT_READY;
          i_q <= '0;
        end
        OP_CLR: begin
          i_q <= i_q + CNT_BITS'(1);
          if (i_q == CNT_BITS'(MAX_ELEMENTS - 1)) begin
            i_q     <= '0;
            full_q  <= (step_eff == STEP_BITS'(1));
            built_q <= 1'b1;
          end
        end
        OP_F_RD, OP_B_RD: if (i_q >= cnt_q && bad_q) sts_q <= ST_CORRUPT;
        OP_F_V: j_q <= perm_rd;
        OP_F_CHK: begin
          if (({1'b0, j_q} >= cnt_q) || vis_rd) bad_q <= 1'b1;
          i_q <= i_q + CNT_BITS'(1);
        end
        OP_B_VIS: begin
          if (vis_rd) begin
            i_q <= i_q + CNT_BITS'(1);
          end else begin
            ptr_q  <= i_q[INDEX_BITS-1:0];
            aux_q  <= '0;
            cyc_q  <= '0;
            walk_q <= '0;
          end
        end
        OP_B_CHK: begin
          if (close) begin
            i_q <= i_q + CNT_BITS'(1);
          end else if (brk) begin
            bad_q <= 1'b1;
            i_q   <= i_q + CNT_BITS'(1);
          end else begin
            walk_q <= walk_q + CNT_BITS'(1);
            cyc_q  <= cyc_q + CNT_BITS'(1);
            if (aux_hit) begin
              ptr_q <= perm_rd;
              aux_q <= '0;
            end else begin
              aux_q <= aux_q + STEP_BITS'(1);
            end
          end
        end
        OP_QSEL: begin
          if (!built_q) sts_q <= ST_NOT_READY;
          else if ({1'b0, opnd_q} >= cnt_q) sts_q <= ST_RANGE;
          j_q    <= opnd_q;
          walk_q <= '0;
        end
        OP_FWD:  res_q <= perm_rd;
        OP_FINV: res_q <= bp_rd;
        OP_Q1: begin
          if (match) begin
            res_q <= j_q;
          end else if (!mark_rd) begin
            if (brk) begin
              sts_q <= ST_CORRUPT;
            end else begin
              walk_q <= walk_q + CNT_BITS'(1);
              j_q    <= perm_rd;
            end
          end else if (bp_bad) begin
            sts_q <= ST_CORRUPT;
          end else begin
            j_q    <= bp_rd;
            walk_q <= '0;
          end
        end
        OP_Q2: begin
          if (match) begin
            res_q <= j_q;
          end else if (brk) begin
            sts_q <= ST_CORRUPT;
          end else begin
            walk_q <= walk_q + CNT_BITS'(1);
            j_q    <= perm_rd;
          end
        end
        default: ;
      endcase
      if (op_i == OP_RESP && out_free) begin
        out_valid_q <= 1'b1;
        out_q       <= '{result_value: res_q, status: sts_q};
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  always_comb begin
    sts_o.last      = last_q;
    sts_o.req       = req_q;
    sts_o.clr_end   = (i_q == CNT_BITS'(MAX_ELEMENTS - 1));
    sts_o.step_full = (step_eff == STEP_BITS'(1));
    sts_o.idx_end   = (i_q >= cnt_q);
    sts_o.vis_hit   = vis_rd;
    sts_o.walk_end  = close || brk;
    sts_o.q_err     = !built_q || ({1'b0, opnd_q} >= cnt_q);
    sts_o.full      = full_q;
    sts_o.q_fin     = (op_i == OP_Q1) ? (match || (!mark_rd && brk) || (mark_rd && bp_bad))
                                      : (match || brk);
    sts_o.q_jump    = !match && mark_rd && !bp_bad;
    sts_o.out_free  = out_free;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_BITS'(MAX_ELEMENTS)) else $error("element count overflow");
  a_built_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    built_q |-> (cnt_q != '0)) else $error("built with no elements");
  a_aux_below_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == OP_B_CHK) |-> (aux_q < step_eff)) else $error("sample counter overran step");
  a_resp_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == OP_RESP && out_free) |=> out_valid_q) else $error("response word lost");

endmodule

/* hw/rtl/permutation_shortcut_inverse_unit.sv */
// top level: permutation store with sampled backward pointers for inverse lookup
//
//  channel  direction  handshake          payload
//  in       input      in_valid/in_stall  psi_in_t   (req_type, operand, last)
//  out      output     out_valid/out_stall psi_out_t (result_value, status)
//  cfg      input      cfg_valid/cfg_ready index, 8-bit data
//
//  one word at a time: the input stalls while a load, build or query is in progress
//  inverse query with sampling: walks forward from the operand, at most one pointer jump
//  build: clears all 1024 mark/visited/pointer entries, then stores a backward pointer
//  per element (full inverse) or per step-th element of each cycle; single memory read port
//  asynchronous active-low reset clears count, built/full flags and out_valid, sets config defaults
//  the result register lets the next word in while a result waits on out_stall
module permutation_shortcut_inverse_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  psi_pkg::psi_in_t                 in_word_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output psi_pkg::psi_out_t                out_word_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [psi_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [psi_pkg::STEP_BITS-1:0]    cfg_data_i
);
  import psi_pkg::*;

  psi_op_e  op;
  psi_sts_t sts;

  assign cfg_ready_o = 1'b1;

  psi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_req_i   (in_word_i.req_type),
    .sts_i      (sts),
    .op_o       (op),
    .in_stall_o (in_stall_o)
  );

  psi_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (op),
    .in_word_i   (in_word_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o),
    .sts_o       (sts)
  );

endmodule
